### hdl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types and constants for the Life automaton grid: command codes,
// rule thresholds and the control and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lag_pkg;

   // Default edge length of the square grid.
   localparam int GRID_SIZE_DEF = 256;

   // Widths of the request and response fields.
   localparam int CMD_W  = 2;
   localparam int ADDR_W = 8;

   // Neighbor counts of rule B3/S23, and the width that holds up to eight.
   localparam int BORN_COUNT = 3;
   localparam int KEEP_COUNT = 2;
   localparam int NBR_W      = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_NOP   = 2'd3
   } lag_cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // capture the incoming request
      logic clear_wr;   // write a zero row at the row counter
      logic cnt_inc;    // advance the row counter
      logic cnt_clear;  // return the row counter to zero
      logic sweep_rd;   // read the row at the row counter for a step
      logic fetch;      // read the addressed row for a cell access
      logic modify;     // addressed row is on the read port
      logic rsp_load;   // load the response register
   } lag_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_row;   // row counter is at the last row
      logic req_step;   // incoming request is a step
      logic req_access; // incoming request reads or writes a cell in range
      logic rsp_free;   // response register can take a result this cycle
   } lag_status_type;

endpackage

### hdl/lag_ram.sv
// ----------------------------------------------------------------------------
// lag_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module lag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lag_ctrl.sv
// ----------------------------------------------------------------------------
// lag_ctrl
// Controller of the Life grid: clears the grid after reset, sequences cell
// accesses and the row sweep of a generation step, and hands each result to
// the response register.
// ----------------------------------------------------------------------------
module lag_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lag_pkg::lag_status_type status,
   output lag_pkg::lag_ctl_type    ctl
);

   import lag_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_ACCESS = 7'b0000100,
      ST_MODIFY = 7'b0001000,
      ST_SWEEP  = 7'b0010000,
      ST_DRAIN  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } lag_state_type;

   lag_state_type state_ff;
   lag_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clear_wr = 1'b1;
            ctl.cnt_inc  = 1'b1;
            if (status.last_row) begin
               ctl.cnt_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            ctl.accept = req_valid;
            if (req_valid) begin
               if (status.req_step) begin
                  state_in = ST_SWEEP;
               end else if (status.req_access) begin
                  state_in = ST_ACCESS;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ACCESS: begin
            ctl.fetch = 1'b1;
            state_in  = ST_MODIFY;
         end
         ST_MODIFY: begin
            ctl.modify = 1'b1;
            state_in   = ST_DONE;
         end
         ST_SWEEP: begin
            ctl.sweep_rd = 1'b1;
            ctl.cnt_inc  = 1'b1;
            if (status.last_row) begin
               ctl.cnt_clear = 1'b1;
               state_in      = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last row arrives now and the row above it is written back.
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/lag_datapath.sv
// ----------------------------------------------------------------------------
// lag_datapath
// Datapath of the Life grid: the row-wide grid memory, the request capture,
// the row counter, the three-row window and next-generation logic of a
// step, and the response register.
// ----------------------------------------------------------------------------
module lag_datapath #(
   parameter int GRID_SIZE = lag_pkg::GRID_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lag_pkg::lag_ctl_type        ctl,
   output lag_pkg::lag_status_type     status,
   input  logic [lag_pkg::CMD_W-1:0]   req_cmd,
   input  logic [lag_pkg::ADDR_W-1:0]  req_row,
   input  logic [lag_pkg::ADDR_W-1:0]  req_col,
   input  logic                        req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_cell_state,
   output logic [lag_pkg::CMD_W-1:0]   rsp_done_cmd
);

   import lag_pkg::*;

   localparam int ROW_W = $clog2(GRID_SIZE);
   localparam int CMP_W = ((ROW_W > ADDR_W) ? ROW_W : ADDR_W) + 1;

   // Request capture.
   lag_cmd_type      cmd_ff;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] col_ff;
   logic             value_ff;
   logic             cell_ff;

   logic [CMP_W-1:0] row_ext;
   logic [CMP_W-1:0] col_ext;
   logic             req_inside;

   // Row counter and sweep tracking.
   logic [ROW_W-1:0] cnt_ff;
   logic [ROW_W-1:0] data_row_ff;
   logic             data_vld_ff;

   // Old-generation window: the two rows above the one on the read port.
   logic [GRID_SIZE-1:0] up_ff;
   logic [GRID_SIZE-1:0] mid_ff;
   logic [GRID_SIZE-1:0] life_row;
   logic [GRID_SIZE-1:0] mod_row;

   // Memory ports.
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_addr;
   logic [GRID_SIZE-1:0] wr_data;
   logic                 rd_en;
   logic [ROW_W-1:0]     rd_addr;
   logic [GRID_SIZE-1:0] rd_data;

   // Response register.
   logic             rsp_valid_ff;
   logic             rsp_cell_ff;
   logic [CMD_W-1:0] rsp_cmd_ff;

   assign row_ext    = CMP_W'(req_row);
   assign col_ext    = CMP_W'(req_col);
   assign req_inside = (row_ext < CMP_W'(GRID_SIZE)) && (col_ext < CMP_W'(GRID_SIZE));

   assign status.last_row   = (cnt_ff == ROW_W'(GRID_SIZE - 1));
   assign status.req_step   = (req_cmd == CMD_STEP);
   assign status.req_access = ((req_cmd == CMD_WRITE) || (req_cmd == CMD_READ)) && req_inside;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff   <= lag_cmd_type'(req_cmd);
         row_ff   <= row_ext[ROW_W-1:0];
         col_ff   <= col_ext[ROW_W-1:0];
         value_ff <= req_value;
         cell_ff  <= 1'b0;
      end else if (ctl.modify) begin
         cell_ff <= (cmd_ff == CMD_READ) ? rd_data[col_ff] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         if (ctl.cnt_clear) begin
            cnt_ff <= '0;
         end else if (ctl.cnt_inc) begin
            cnt_ff <= cnt_ff + ROW_W'(1);
         end
         data_vld_ff <= ctl.sweep_rd;
      end
   end

   always_ff @(posedge clock) begin
      data_row_ff <= cnt_ff;
      if (data_vld_ff) begin
         up_ff  <= mid_ff;
         mid_ff <= rd_data;
      end
   end

   // Next generation of the middle row; its end cells are border cells.
   always_comb begin
      logic [NBR_W-1:0] nbr;
      nbr      = '0;
      life_row = mid_ff;
      for (int c = 1; c < GRID_SIZE - 1; c++) begin
         nbr = NBR_W'(up_ff[c-1]) + NBR_W'(up_ff[c]) + NBR_W'(up_ff[c+1])
             + NBR_W'(mid_ff[c-1]) + NBR_W'(mid_ff[c+1])
             + NBR_W'(rd_data[c-1]) + NBR_W'(rd_data[c]) + NBR_W'(rd_data[c+1]);
         life_row[c] = (nbr == NBR_W'(BORN_COUNT))
                     || (mid_ff[c] && (nbr == NBR_W'(KEEP_COUNT)));
      end
   end

   always_comb begin
      mod_row         = rd_data;
      mod_row[col_ff] = value_ff;
   end

   // The first and last rows are never written by a step: a row is written
   // back only once the row below it has been read, and row zero is skipped.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = '0;
      if (ctl.clear_wr) begin
         wr_en = 1'b1;
      end else if (data_vld_ff && (data_row_ff >= ROW_W'(2))) begin
         wr_en   = 1'b1;
         wr_addr = data_row_ff - ROW_W'(1);
         wr_data = life_row;
      end else if (ctl.modify && (cmd_ff == CMD_WRITE)) begin
         wr_en   = 1'b1;
         wr_addr = row_ff;
         wr_data = mod_row;
      end
   end

   assign rd_en   = ctl.sweep_rd || ctl.fetch;
   assign rd_addr = ctl.sweep_rd ? cnt_ff : row_ff;

   lag_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_cell_ff <= cell_ff;
         rsp_cmd_ff  <= cmd_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_state = rsp_cell_ff;
   assign rsp_done_cmd   = rsp_cmd_ff;

endmodule

### hdl/life_automaton_grid_top.sv
// ----------------------------------------------------------------------------
// life_automaton_grid_top
// Square grid of one-bit cells under the Life rule B3/S23, driven by
// write, read and step requests.
// ----------------------------------------------------------------------------
// Each request on the req_ channel carries a command, a row, a column and a
// value, and yields exactly one response on the rsp_ channel with the cell
// read (zero otherwise) and the command echoed.
// The grid is stored one row per memory word. After reset the block
// clears the grid, one row per cycle, and takes no request until that
// pass is done. A write or read of a cell in range reads the row, then
// modifies or samples it, and loads the result into the response
// register before the block is ready again. An index out of range or an
// unused command goes straight to the response register. A step sweeps
// all rows through the single memory read port, one row per cycle.
// The response is registered: a new request is accepted while the last
// response still waits, and a command only stalls at its end if that
// response has not been taken by then.
// ----------------------------------------------------------------------------
module life_automaton_grid_top #(
   parameter int GRID_SIZE = lag_pkg::GRID_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [lag_pkg::CMD_W-1:0]  req_cmd,
   input  logic [lag_pkg::ADDR_W-1:0] req_row,
   input  logic [lag_pkg::ADDR_W-1:0] req_col,
   input  logic                       req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_cell_state,
   output logic [lag_pkg::CMD_W-1:0]  rsp_done_cmd
);

   import lag_pkg::*;

   lag_ctl_type    ctl;
   lag_status_type status;

   lag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctl       (ctl)
   );

   lag_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .status         (status),
      .req_cmd        (req_cmd),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_state (rsp_cell_state),
      .rsp_done_cmd   (rsp_done_cmd)
   );

endmodule

### verif/life_automaton_grid_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_grid_top_tb
// Self-checking bench for the Life automaton grid under rule B3/S23.
// ----------------------------------------------------------------------------
// A shadow copy of the grid follows every accepted request, and each response
// is checked against it in order. A short table of hand-picked requests covers
// the corners, the unused command, border cells and a blinker. Random episodes
// then seed small windows of cells, step them and read them back, mixed with
// scattered accesses over the whole address range. Both channels stall in
// random bursts, except in a recurring window and in the last part of the run.
// ----------------------------------------------------------------------------
module life_automaton_grid_top_tb;
   import lag_pkg::*;

   localparam int GRID_N       = GRID_SIZE_DEF;
   localparam int DIRECTED_N   = 25;
   localparam int RANDOM_ITEMS = 1525;
   localparam int CYCLE_LIMIT  = 1_500_000;

   typedef struct {
      lag_cmd_type cmd;
      logic [7:0]  row;
      logic [7:0]  col;
      logic        value;
      bit          typed;
      logic        typed_cell;
   } life_probe_type;

   typedef struct {
      logic        cell_bit;
      lag_cmd_type cmd;
   } life_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   lag_cmd_type req_cmd;
   logic [7:0]  req_row;
   logic [7:0]  req_col;
   logic        req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_cell_state;
   logic [1:0]  rsp_done_cmd;

   // Hand-typed expectation that travels with the request being offered.
   bit          req_typed;
   logic        req_typed_cell;

   logic [GRID_N-1:0] shadow_rows [GRID_N];
   life_rsp_type      expected_rsp_q [$];

   int  cycle_count = 0;
   int  sent_count  = 0;
   int  fail_count  = 0;
   int  n_write = 0, n_read = 0, n_live = 0, n_step = 0, n_nop = 0, n_checked = 0;
   bit  quiet_tail  = 1'b0;

   life_probe_type probe_table [DIRECTED_N] = '{
      '{CMD_READ,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{CMD_READ,  8'd255, 8'd255, 1'b0, 1'b1, 1'b0},
      '{CMD_WRITE, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{CMD_READ,  8'd255, 8'd255, 1'b0, 1'b1, 1'b1},
      '{CMD_WRITE, 8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{CMD_READ,  8'd0,   8'd0,   1'b0, 1'b1, 1'b1},
      '{CMD_NOP,   8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{CMD_WRITE, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{CMD_READ,  8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
      '{CMD_WRITE, 8'd0,   8'd1,   1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, 8'd0,   8'd2,   1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, 8'd0,   8'd3,   1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, 8'd10,  8'd9,   1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, 8'd10,  8'd10,  1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, 8'd10,  8'd11,  1'b1, 1'b0, 1'b0},
      '{CMD_STEP,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
      '{CMD_READ,  8'd0,   8'd2,   1'b0, 1'b0, 1'b0},
      '{CMD_READ,  8'd1,   8'd2,   1'b0, 1'b0, 1'b0},
      '{CMD_READ,  8'd9,   8'd10,  1'b0, 1'b0, 1'b0},
      '{CMD_READ,  8'd10,  8'd9,   1'b0, 1'b0, 1'b0},
      '{CMD_STEP,  8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{CMD_READ,  8'd10,  8'd9,   1'b0, 1'b0, 1'b0},
      '{CMD_READ,  8'd9,   8'd10,  1'b0, 1'b0, 1'b0},
      '{CMD_READ,  8'd255, 8'd255, 1'b0, 1'b0, 1'b0},
      '{CMD_NOP,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0}
   };

   life_automaton_grid_top #(
      .GRID_SIZE(GRID_N)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_state(rsp_cell_state),
      .rsp_done_cmd  (rsp_done_cmd)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Next generation of the interior. Each row is handled as one vector: the
   // eight neighbor vectors are summed bit-sliced, and a count of eight wraps
   // to zero, which neither survives nor gives birth.
   function automatic void advance_generation();
      logic [GRID_N-1:0] prev [GRID_N];
      logic [GRID_N-1:0] nbr [8];
      logic [GRID_N-1:0] s0, s1, s2, c0, c1, self, nxt;
      prev = shadow_rows;
      for (int r = 1; r < GRID_N - 1; r++) begin
         self = prev[r];
         nbr = '{prev[r-1] << 1, prev[r-1], prev[r-1] >> 1, self << 1, self >> 1,
                 prev[r+1] << 1, prev[r+1], prev[r+1] >> 1};
         s0 = '0;
         s1 = '0;
         s2 = '0;
         foreach (nbr[k]) begin
            c0 = s0 & nbr[k];
            s0 = s0 ^ nbr[k];
            c1 = s1 & c0;
            s1 = s1 ^ c0;
            s2 = s2 ^ c1;
         end
         nxt = s1 & ~s2 & (s0 | self);
         nxt[0] = self[0];
         nxt[GRID_N-1] = self[GRID_N-1];
         shadow_rows[r] = nxt;
      end
   endfunction

   function automatic logic apply_request(lag_cmd_type cmd, logic [7:0] row,
                                          logic [7:0] col, logic value);
      bit in_range;
      in_range = (row < GRID_N) && (col < GRID_N);
      case (cmd)
         CMD_WRITE: begin
            if (in_range) shadow_rows[row][col] = value;
         end
         CMD_READ: begin
            if (in_range) return shadow_rows[row][col];
         end
         CMD_STEP: begin
            advance_generation();
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Responses are checked before the request of the same edge is predicted;
   // a response can never belong to a request accepted at that edge.
   always @(posedge clock) begin : rsp_check
      life_rsp_type want;
      logic         predicted;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request outstanding: cell_state %0b done_cmd %0d",
                      rsp_cell_state, rsp_done_cmd);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               n_checked++;
               if (rsp_cell_state !== want.cell_bit) begin
                  $error("cell_state: expected %0b, actual %0b", want.cell_bit,
                         rsp_cell_state);
                  fail_count++;
               end
               if (rsp_done_cmd !== want.cmd) begin
                  $error("done_cmd: expected %0d, actual %0d", want.cmd, rsp_done_cmd);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = apply_request(req_cmd, req_row, req_col, req_value);
            want.cell_bit = req_typed ? req_typed_cell : predicted;
            want.cmd      = req_cmd;
            expected_rsp_q.push_back(want);
            case (req_cmd)
               CMD_WRITE: n_write++;
               CMD_READ: begin
                  n_read++;
                  if (predicted) n_live++;
               end
               CMD_STEP: n_step++;
               default: n_nop++;
            endcase
         end
      end
   end

   // Response side: random stall bursts, switched off in a recurring window set
   // by the cycle counter and in the tail of the run.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && cycle_count[8:7] != 2'b00 &&
                      $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(lag_cmd_type cmd, logic [7:0] row, logic [7:0] col,
                               logic value, bit typed = 1'b0, logic typed_cell = 1'b0);
      if (!quiet_tail && cycle_count[8:7] != 2'b00 && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_row        <= row;
      req_col        <= col;
      req_value      <= value;
      req_typed      <= typed;
      req_typed_cell <= typed_cell;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               CYCLE_LIMIT, expected_rsp_q.size());
      $display("life_automaton_grid_top verification failed");
      $finish;
   end

   initial begin : stimulus
      int         kind;
      bit         paused_mid;
      logic [7:0] base_row, base_col, r, c;
      paused_mid = 1'b0;
      foreach (shadow_rows[i]) shadow_rows[i] = '0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_NOP;
      req_row        <= '0;
      req_col        <= '0;
      req_value      <= 1'b0;
      req_typed      <= 1'b0;
      req_typed_cell <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i]) begin
         send_request(probe_table[i].cmd, probe_table[i].row, probe_table[i].col,
                      probe_table[i].value, probe_table[i].typed, probe_table[i].typed_cell);
      end
      drain_responses();

      while (sent_count < DIRECTED_N + RANDOM_ITEMS) begin
         quiet_tail = sent_count > DIRECTED_N + RANDOM_ITEMS * 7 / 8;
         if (!paused_mid && sent_count > DIRECTED_N + RANDOM_ITEMS / 2) begin
            drain_responses();
            paused_mid = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            // Seed an 8x8 window, often against an edge of the grid, let it
            // evolve and read back a slightly larger window.
            base_row = ($urandom_range(0, 3) == 0) ?
                       ($urandom_range(0, 1) ? 8'd248 : 8'd0) : 8'($urandom_range(0, 248));
            base_col = ($urandom_range(0, 3) == 0) ?
                       ($urandom_range(0, 1) ? 8'd248 : 8'd0) : 8'($urandom_range(0, 248));
            repeat ($urandom_range(4, 14)) begin
               send_request(CMD_WRITE, base_row + 8'($urandom_range(0, 7)),
                            base_col + 8'($urandom_range(0, 7)), $urandom_range(0, 3) != 0);
            end
            repeat ($urandom_range(1, 3)) begin
               send_request(CMD_STEP, 8'($urandom), 8'($urandom), 1'($urandom));
            end
            repeat ($urandom_range(6, 16)) begin
               send_request(CMD_READ, base_row + 8'($urandom_range(0, 9)) - 8'd1,
                            base_col + 8'($urandom_range(0, 9)) - 8'd1, 1'($urandom));
            end
         end else if (kind < 9) begin
            repeat ($urandom_range(5, 15)) begin
               send_request(lag_cmd_type'($urandom_range(0, 3)), 8'($urandom),
                            8'($urandom), 1'($urandom));
            end
         end else begin
            // Write and read back a cell with no step between, then an
            // unused command.
            r = 8'($urandom);
            c = 8'($urandom);
            send_request(CMD_WRITE, r, c, 1'($urandom));
            send_request(CMD_READ, r, c, 1'($urandom));
            send_request(CMD_NOP, 8'($urandom), 8'($urandom), 1'($urandom));
         end
      end

      drain_responses();
      repeat (GRID_N + 16) @(posedge clock);
      $display("Covered %0d requests: %0d writes, %0d reads (%0d live), %0d steps, %0d unused.",
               sent_count, n_write, n_read, n_live, n_step, n_nop);
      $display("Compared %0d responses against the shadow grid, %0d mismatches.",
               n_checked, fail_count);
      if (fail_count == 0) begin
         $display("life_automaton_grid_top verification clean");
      end else begin
         $display("life_automaton_grid_top verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/lag_pkg.sv
hdl/lag_ram.sv
hdl/lag_ctrl.sv
hdl/lag_datapath.sv
hdl/life_automaton_grid_top.sv
verif/life_automaton_grid_top_tb.sv
